// ===== hw/rtl/header_length_xor_deframer_core_defines.svh =====
// Assertion macros for the header/length/XOR deframer.
// Included by the top level; no other dependencies.
`ifndef HEADER_LENGTH_XOR_DEFRAMER_CORE_DEFINES_SVH
`define HEADER_LENGTH_XOR_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HLXD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define HLXD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== hw/rtl/hlxd_pkg.sv =====
// Shared types and constants for the header/length/XOR deframer.
// No dependencies.
package hlxd_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;
    localparam logic [1:0] KIND_LONG = 2'd3;

    localparam logic CFG_START_BYTE  = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [7:0]  START_BYTE_RST  = 8'h9F;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1020;

    localparam logic [15:0] LEN_HI_MASK = 16'hFF00;
    localparam logic [15:0] LEN_LO_MASK = 16'h00FF;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
    } result_t;

endpackage

// ===== hw/rtl/hlxd_parser.sv =====
// Frame parser state machine: hunt, length, payload and check phases.
// Depends on hlxd_pkg.
module hlxd_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      rx_byte,
    input  logic            flush,
    input  hlxd_pkg::cfg_t  cfg,
    output hlxd_pkg::result_t res
);
    import hlxd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] len_lo;
    logic [7:0]  xor_in;

    assign len_lo = (len_reg & LEN_HI_MASK) | ({8'h00, rx_byte} & LEN_LO_MASK);
    assign xor_in = xor_reg ^ rx_byte;

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        xor_next   = xor_reg;
        res        = '0;
        if (step) begin
            if (flush) begin
                phase_next = PH_HUNT;
                len_next   = '0;
                left_next  = '0;
                xor_next   = '0;
            end else begin
                case (phase_reg)
                    PH_LEN_HI: begin
                        len_next   = {rx_byte, 8'h00} & LEN_HI_MASK;
                        xor_next   = rx_byte;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        if (len_lo > cfg.max_payload) begin
                            phase_next       = PH_HUNT;
                            len_next         = '0;
                            left_next        = '0;
                            xor_next         = '0;
                            res.valid        = 1'b1;
                            res.kind         = KIND_LONG;
                            res.frame_length = len_lo;
                        end else begin
                            len_next   = len_lo;
                            left_next  = len_lo;
                            xor_next   = xor_in;
                            phase_next = (len_lo == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        xor_next  = xor_in;
                        left_next = left_reg - 16'd1;
                        if (left_reg == 16'd1) begin
                            phase_next = PH_CHECK;
                        end
                        res.valid     = 1'b1;
                        res.kind      = KIND_DATA;
                        res.data_byte = rx_byte;
                    end
                    PH_CHECK: begin
                        phase_next       = PH_HUNT;
                        len_next         = '0;
                        left_next        = '0;
                        xor_next         = '0;
                        res.valid        = 1'b1;
                        res.kind         = (xor_in == 8'h00) ? KIND_GOOD : KIND_BAD;
                        res.frame_length = len_reg;
                    end
                    default: begin
                        len_next   = '0;
                        left_next  = '0;
                        xor_next   = '0;
                        phase_next = (rx_byte == cfg.start_byte) ? PH_LEN_HI : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            left_reg  <= '0;
            xor_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

// ===== hw/rtl/header_length_xor_deframer_core.sv =====
// Header/length/XOR deframer: start byte, big-endian length, payload, check byte.
// Block use: one received byte per input transfer on s_valid/s_ready with s_rx_byte
// and s_flush. Results leave on m_valid/m_ready: kind, data_byte, frame_length.
// A transfer enters an input register; when the output register is empty or
// being drained, the parser updates its state and, when the byte yields a
// result, loads the output register. One byte per cycle is sustained while
// m_ready stays high, since the input register refills in the same cycle it
// is drained.
// When the receiver holds m_ready low with a result pending, the input
// register keeps one more byte, then s_ready drops until the result is taken.
// Registers are written over cfg_valid/cfg_ready (always ready): index 0 is
// the start byte (reset 0x9F), index 1 the largest payload length (reset 1020).
// Write them only while the block is idle.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults and returns the parser to hunting for the start byte.
// Depends on hlxd_pkg, hlxd_parser and header_length_xor_deframer_core_defines.svh.
`include "header_length_xor_deframer_core_defines.svh"

module header_length_xor_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_flush,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_frame_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import hlxd_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_flush_reg;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg;
    logic [7:0]  m_data_reg;
    logic [15:0] m_len_reg;
    logic        advance;
    logic        in_take;
    result_t     res;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign in_take   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    hlxd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .flush   (in_flush_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_START_BYTE:  cfg_next.start_byte  = cfg_data[7:0];
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
        in_valid_next = in_take ? 1'b1 : (in_valid_reg && !advance);
        m_valid_next  = advance ? res.valid : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= START_BYTE_RST;
            cfg_reg.max_payload <= MAX_PAYLOAD_RST;
            in_valid_reg        <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg  <= s_rx_byte;
            in_flush_reg <= s_flush;
        end
        if (advance && res.valid) begin
            m_kind_reg <= res.kind;
            m_data_reg <= res.data_byte;
            m_len_reg  <= res.frame_length;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_data_byte    = m_data_reg;
    assign m_frame_length = m_len_reg;

    `HLXD_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_ready, in_valid_reg && m_valid_reg && !m_ready)
    `HLXD_ASSERT_IMP(a_data_no_len, aclk, aresetn, m_valid && m_kind == KIND_DATA,
                     m_frame_length == 16'd0)
    `HLXD_ASSERT_IMP(a_end_no_data, aclk, aresetn, m_valid && m_kind != KIND_DATA,
                     m_data_byte == 8'h00)
    `HLXD_ASSERT_NXT(a_flush_silent, aclk, aresetn,
                     advance && in_flush_reg && !(m_valid_reg && !m_ready), !m_valid)

endmodule

// ===== tb/header_length_xor_deframer_core_tb.sv =====
// Self-checking testbench for header_length_xor_deframer_core.
// A scoreboard class predicts each result from the accepted byte stream.
// Depends on hlxd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module header_length_xor_deframer_core_tb;
    import hlxd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD = 400;

    typedef enum logic [2:0] {
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CHECK
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
    } frame_result_t;

    class frame_scoreboard;
        logic [7:0]    start_byte;
        logic [15:0]   max_payload;
        parse_phase_t  phase;
        logic [15:0]   frame_len;
        logic [15:0]   left;
        logic [7:0]    xsum;
        frame_result_t expected_q[$];
        int            errors;

        function new();
            start_byte = START_BYTE_RST;
            max_payload = MAX_PAYLOAD_RST;
            errors = 0;
            go_hunt();
        endfunction

        function void go_hunt();
            phase = PH_HUNT;
            frame_len = 16'h0000;
            left = 16'h0000;
            xsum = 8'h00;
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == CFG_START_BYTE)
                start_byte = value[7:0];
            else
                max_payload = value;
        endfunction

        function void note_byte(logic [7:0] b, logic flush);
            frame_result_t r;
            logic          has;
            has = 1'b0;
            r = '0;
            if (flush) begin
                go_hunt();
                return;
            end
            case (phase)
                PH_LEN_HI: begin
                    frame_len = {b, 8'h00} & LEN_HI_MASK;
                    xsum = b;
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len = (frame_len & LEN_HI_MASK) | ({8'h00, b} & LEN_LO_MASK);
                    xsum ^= b;
                    if (frame_len > max_payload) begin
                        r = '{KIND_LONG, 8'h00, frame_len};
                        has = 1'b1;
                        go_hunt();
                    end else begin
                        left = frame_len;
                        phase = (left == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    xsum ^= b;
                    left = left - 16'd1;
                    if (left == 16'h0000)
                        phase = PH_CHECK;
                    r = '{KIND_DATA, b, 16'h0000};
                    has = 1'b1;
                end
                PH_CHECK: begin
                    xsum ^= b;
                    r = '{(xsum == 8'h00) ? KIND_GOOD : KIND_BAD, 8'h00, frame_len};
                    has = 1'b1;
                    go_hunt();
                end
                default: begin
                    go_hunt();
                    if (b == start_byte)
                        phase = PH_LEN_HI;
                end
            endcase
            if (has)
                expected_q.push_back(r);
        endfunction

        function void check(logic [1:0] kind, logic [7:0] data_byte, logic [15:0] frame_length);
            frame_result_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result: kind %0d data_byte %0h frame_length %0d",
                       kind, data_byte, frame_length);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (kind !== e.kind) begin
                $error("kind mismatch: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (data_byte !== e.data_byte) begin
                $error("data_byte mismatch: expected %0h, actual %0h", e.data_byte, data_byte);
                errors++;
            end
            if (frame_length !== e.frame_length) begin
                $error("frame_length mismatch: expected %0d, actual %0d",
                       e.frame_length, frame_length);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_flush = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [15:0] m_frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_START_BYTE;
    logic [15:0] cfg_data = 16'h0000;

    frame_scoreboard sb = new();

    int cycle_count = 0;
    int frame_items = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int ready_mode = 0;
    int mode_left = 0;
    int ready_tick = 0;

    header_length_xor_deframer_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_flush        (s_flush),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check(m_kind, m_data_byte, m_frame_length);
    end

    // receiver: random stall pattern, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left = mode_left - 1;
            ready_tick = ready_tick + 1;
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= ((ready_tick % 8) < 5);
            endcase
        end
    end

    task automatic push(logic [7:0] b, logic f, bit counted);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_rx_byte <= b;
        s_flush <= f;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, f);
        if (counted)
            frame_items++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [7:0] start, logic [15:0] max_len);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_data <= {8'h00, start};
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_START_BYTE, {8'h00, start});
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data <= max_len;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_MAX_PAYLOAD, max_len);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed frames; some with bad check, too long, or flushed
    task automatic random_frame(int cap, int fixed_len);
        int         n;
        int         len;
        int         style;
        int         lim;
        logic [7:0] b;
        logic [7:0] x;
        n = $urandom_range(0, 2);
        repeat (n) begin
            b = 8'($urandom);
            if (b == sb.start_byte)
                b = ~b;
            push(b, ($urandom_range(0, 15) == 0), 1'b0);
        end
        push(sb.start_byte, 1'b0, 1'b1);
        style = $urandom_range(0, 19);
        lim = (cap < sb.max_payload) ? cap : sb.max_payload;
        if (fixed_len >= 0)
            len = fixed_len;
        else if (style == 0 && sb.max_payload != 16'hFFFF)
            len = $urandom_range(sb.max_payload + 1, 65535);
        else
            len = $urandom_range(0, lim);
        if (style == 4 && fixed_len < 0) begin
            push(8'($urandom), 1'b1, 1'b1);
            return;
        end
        push(len[15:8], 1'b0, 1'b1);
        push(len[7:0], 1'b0, 1'b1);
        x = len[15:8] ^ len[7:0];
        if (len > sb.max_payload)
            return;
        for (int i = 0; i < len; i++) begin
            if (style == 1 && fixed_len < 0 && i == len / 2) begin
                push(8'($urandom), 1'b1, 1'b1);
                return;
            end
            b = 8'($urandom);
            x ^= b;
            push(b, 1'b0, 1'b1);
        end
        if (style == 2 || style == 3)
            b = x ^ (8'h01 << $urandom_range(0, 7));
        else if (style == 5)
            b = 8'($urandom);
        else
            b = x;
        push(b, 1'b0, 1'b1);
    endtask

    task automatic random_phase(int cap, int count);
        int target;
        target = frame_items + count;
        while (frame_items < target)
            random_frame(cap, -1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // noise and flush while hunting
        push(8'h00, 1'b0, 1'b1);
        push(8'hFF, 1'b0, 1'b1);
        push(8'h9F, 1'b1, 1'b1);
        // start byte inside payload, good check
        push(8'h9F, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h02, 1'b0, 1'b1);
        push(8'h9F, 1'b0, 1'b1);
        push(8'hFF, 1'b0, 1'b1);
        push(8'h62, 1'b0, 1'b1);
        // zero length, good; then one byte with bad check
        push(8'h9F, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h9F, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h01, 1'b0, 1'b1);
        push(8'h55, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        // too long by one, then a flush in the check phase
        push(8'h9F, 1'b0, 1'b1);
        push(8'h03, 1'b0, 1'b1);
        push(8'hFD, 1'b0, 1'b1);
        push(8'h9F, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h01, 1'b0, 1'b1);
        push(8'hAA, 1'b0, 1'b1);
        push(8'h00, 1'b1, 1'b1);

        // hold off the receiver while a long frame keeps coming
        hold_requests++;
        random_frame(48, 48);
        random_phase(24, 120);

        configure(8'h00, 16'h0000);
        push(8'h00, 1'b0, 1'b1);
        push(8'hFF, 1'b0, 1'b1);
        push(8'hFF, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        push(8'h00, 1'b0, 1'b1);
        random_phase(0, 80);

        configure(8'hFF, 16'hFFFF);
        push(8'hFF, 1'b0, 1'b1);
        push(8'hFF, 1'b0, 1'b1);
        push(8'hFF, 1'b0, 1'b1);
        push(8'h12, 1'b1, 1'b1);
        random_phase(20, 100);

        configure(8'($urandom), 16'($urandom_range(0, 30)));
        hold_requests++;
        random_phase(30, 100);

        configure(8'($urandom), 16'($urandom));
        random_phase(20, 100);

        configure(START_BYTE_RST, MAX_PAYLOAD_RST);
        random_phase(24, 40);

        settle();
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== header_length_xor_deframer_core.f =====
+incdir+hw/rtl
hw/rtl/hlxd_pkg.sv
hw/rtl/hlxd_parser.sv
hw/rtl/header_length_xor_deframer_core.sv
tb/header_length_xor_deframer_core_tb.sv
